FILE: sv/bpc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
// No dependencies.
package bpc_pkg;

    typedef enum logic [2:0] {
        CFG_PRESSURE_SENSITIVITY      = 3'd0,
        CFG_PRESSURE_OFFSET           = 3'd1,
        CFG_SENS_TEMP_COEFF           = 3'd2,
        CFG_OFFSET_TEMP_COEFF         = 3'd3,
        CFG_REFERENCE_TEMPERATURE     = 3'd4,
        CFG_TEMP_COEFF_OF_TEMPERATURE = 3'd5
    } t_cfg_reg;

    typedef logic signed [18:0] t_temp;
    typedef logic [15:0]        t_coeff;

    localparam int unsigned NUM_STAGES = 10;

    localparam t_temp TEMP_REF  = 19'sd2000;
    localparam t_temp TEMP_VLOW = -19'sd1500;

    localparam logic signed [43:0] P_MAX = 44'sd2147483647;
    localparam logic signed [43:0] P_MIN = -44'sd2147483648;

endpackage

FILE: sv/baro_pressure_temp_compensation.sv
// Barometric pressure and temperature compensation, ten-stage pipeline.
// Depends on bpc_pkg (sv/bpc_pkg.sv).
//
// Unless the output stalls, one beat of raw pressure and temperature enters per cycle
// and one compensated beat leaves per cycle. The partial products of the final
// 24 x 40 bit pressure multiply are split across two stages. A stalled output
// holds only the stages behind it that are full, so bubbles close up and the input
// stays ready while the pipeline has room. Calibration words are to be written
// through the configuration port only while no beat is in flight; the block does
// not enforce this. Writes to unused indexes are dropped.
module baro_pressure_temp_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [23:0]        i_pressure_raw,
    input  logic [23:0]        i_temperature_raw,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pressure_pa,
    output logic signed [18:0] o_temperature_centi
);

    localparam logic signed [41:0] B23 = 42'sd8388607;
    localparam logic signed [41:0] B7  = 42'sd127;
    localparam logic signed [41:0] B8  = 42'sd255;
    localparam logic signed [63:0] B21 = 64'sd2097151;
    localparam logic signed [43:0] B15 = 44'sd32767;

    bpc_pkg::t_coeff r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    logic [bpc_pkg::NUM_STAGES:1] r_v;
    logic [bpc_pkg::NUM_STAGES:1] w_en;

    // stage registers
    logic [23:0]        r1_d1;
    logic signed [24:0] r1_dt;

    logic [23:0]        r2_d1;
    logic signed [41:0] r2_pt, r2_po, r2_ps;
    logic [47:0]        r2_pdd;

    logic [23:0]        r3_d1;
    bpc_pkg::t_temp     r3_temp;
    logic signed [35:0] r3_off, r3_sens;
    logic [16:0]        r3_t2;

    logic [23:0]        r4_d1;
    logic signed [35:0] r4_off, r4_sens;
    logic [35:0]        r4_lo, r4_vl;
    logic               r4_low, r4_vlow;
    bpc_pkg::t_temp     r4_tc;

    logic [23:0]        r5_d1;
    logic signed [35:0] r5_off, r5_sens;
    logic [38:0]        r5_off2, r5_sens2;
    logic               r5_low, r5_vlow;
    bpc_pkg::t_temp     r5_tc;

    logic [23:0]        r6_d1;
    logic signed [39:0] r6_offc, r6_sensc;
    bpc_pkg::t_temp     r6_tc;

    logic signed [44:0] r7_ph;
    logic [43:0]        r7_pl;
    logic signed [39:0] r7_off;
    bpc_pkg::t_temp     r7_tc;

    logic signed [63:0] r8_x;
    logic signed [39:0] r8_off;
    bpc_pkg::t_temp     r8_tc;

    logic signed [43:0] r9_q;
    bpc_pkg::t_temp     r9_tc;

    logic signed [31:0] r10_p;
    bpc_pkg::t_temp     r10_tc;

    // combinational next values
    logic signed [24:0] n1_dt;
    logic signed [16:0] w_c6s, w_c4s, w_c3s;
    logic signed [41:0] n2_pt, n2_po, n2_ps;
    logic signed [49:0] w_dd;
    logic signed [41:0] w_pt_b, w_pt_q, w_po_b, w_po_q, w_ps_b, w_ps_q;
    bpc_pkg::t_temp     n3_temp;
    logic signed [35:0] n3_off, n3_sens;
    logic               w_low, w_vlow;
    bpc_pkg::t_temp     w_lo_d, w_vl_d;
    logic signed [37:0] w_lo_sq, w_vl_sq;
    logic signed [19:0] w_tc;
    logic [38:0]        n5_off2, n5_sens2;
    logic signed [39:0] n6_offc, n6_sensc;
    logic signed [24:0] w_d1s;
    logic signed [44:0] n7_ph;
    logic [43:0]        n7_pl;
    logic signed [63:0] n8_x;
    logic signed [63:0] w_x_b, w_x_q;
    logic signed [43:0] n9_q;
    logic signed [43:0] w_q_b, w_q_q;
    logic signed [31:0] n10_p;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_valid) begin
            case (bpc_pkg::t_cfg_reg'(i_cfg_index))
                bpc_pkg::CFG_PRESSURE_SENSITIVITY:      r_c1 <= i_cfg_data;
                bpc_pkg::CFG_PRESSURE_OFFSET:           r_c2 <= i_cfg_data;
                bpc_pkg::CFG_SENS_TEMP_COEFF:           r_c3 <= i_cfg_data;
                bpc_pkg::CFG_OFFSET_TEMP_COEFF:         r_c4 <= i_cfg_data;
                bpc_pkg::CFG_REFERENCE_TEMPERATURE:     r_c5 <= i_cfg_data;
                bpc_pkg::CFG_TEMP_COEFF_OF_TEMPERATURE: r_c6 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // stall chain: a stage advances when empty or when the one after it advances
    always_comb begin
        w_en[bpc_pkg::NUM_STAGES] = !r_v[bpc_pkg::NUM_STAGES] || i_ready;
        for (int k = bpc_pkg::NUM_STAGES - 1; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k + 1];
        end
    end

    assign o_ready = w_en[1];
    assign o_valid = r_v[bpc_pkg::NUM_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= bpc_pkg::NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k - 1];
                end
            end
        end
    end

    // datapath
    always_comb begin
        n1_dt = $signed({1'b0, i_temperature_raw}) - $signed({1'b0, r_c5, 8'h00});

        w_c6s = $signed({1'b0, r_c6});
        w_c4s = $signed({1'b0, r_c4});
        w_c3s = $signed({1'b0, r_c3});
        n2_pt = r1_dt * w_c6s;
        n2_po = r1_dt * w_c4s;
        n2_ps = r1_dt * w_c3s;
        w_dd  = r1_dt * r1_dt;

        w_pt_b  = r2_pt + (r2_pt[41] ? B23 : 42'sd0);
        w_pt_q  = w_pt_b >>> 23;
        n3_temp = $signed(w_pt_q[18:0]) + bpc_pkg::TEMP_REF;
        w_po_b  = r2_po + (r2_po[41] ? B7 : 42'sd0);
        w_po_q  = w_po_b >>> 7;
        n3_off  = $signed(w_po_q[35:0]) + $signed({4'b0, r_c2, 16'h0000});
        w_ps_b  = r2_ps + (r2_ps[41] ? B8 : 42'sd0);
        w_ps_q  = w_ps_b >>> 8;
        n3_sens = $signed(w_ps_q[35:0]) + $signed({5'b0, r_c1, 15'h0000});

        w_low   = r3_temp < bpc_pkg::TEMP_REF;
        w_vlow  = r3_temp < bpc_pkg::TEMP_VLOW;
        w_lo_d  = r3_temp - bpc_pkg::TEMP_REF;
        w_vl_d  = r3_temp - bpc_pkg::TEMP_VLOW;
        w_lo_sq = w_lo_d * w_lo_d;
        w_vl_sq = w_vl_d * w_vl_d;
        w_tc    = $signed({r3_temp[18], r3_temp})
                - $signed(w_low ? {3'b000, r3_t2} : 20'd0);

        n5_off2  = (r4_low  ? ((39'(r4_lo) * 39'd5) >> 1) : 39'd0)
                 + (r4_vlow ? (39'(r4_vl) * 39'd7) : 39'd0);
        n5_sens2 = (r4_low  ? ((39'(r4_lo) * 39'd5) >> 2) : 39'd0)
                 + (r4_vlow ? ((39'(r4_vl) * 39'd11) >> 1) : 39'd0);

        n6_offc  = 40'(r5_off)  - $signed({1'b0, r5_off2});
        n6_sensc = 40'(r5_sens) - $signed({1'b0, r5_sens2});

        w_d1s = $signed({1'b0, r6_d1});
        n7_ph = w_d1s * $signed(r6_sensc[39:20]);
        n7_pl = 44'(r6_d1) * 44'(r6_sensc[19:0]);

        n8_x = (64'(r7_ph) <<< 20) + $signed({20'h00000, r7_pl});

        w_x_b = r8_x + (r8_x[63] ? B21 : 64'sd0);
        w_x_q = w_x_b >>> 21;
        n9_q  = $signed(w_x_q[43:0]) - 44'(r8_off);

        w_q_b = r9_q + (r9_q[43] ? B15 : 44'sd0);
        w_q_q = w_q_b >>> 15;
        if (w_q_q > bpc_pkg::P_MAX) begin
            n10_p = 32'sh7FFFFFFF;
        end else if (w_q_q < bpc_pkg::P_MIN) begin
            n10_p = 32'sh80000000;
        end else begin
            n10_p = w_q_q[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_d1 <= i_pressure_raw;
            r1_dt <= n1_dt;
        end
        if (w_en[2]) begin
            r2_d1  <= r1_d1;
            r2_pt  <= n2_pt;
            r2_po  <= n2_po;
            r2_ps  <= n2_ps;
            r2_pdd <= w_dd[47:0];
        end
        if (w_en[3]) begin
            r3_d1   <= r2_d1;
            r3_temp <= n3_temp;
            r3_off  <= n3_off;
            r3_sens <= n3_sens;
            r3_t2   <= r2_pdd[47:31];
        end
        if (w_en[4]) begin
            r4_d1   <= r3_d1;
            r4_off  <= r3_off;
            r4_sens <= r3_sens;
            r4_lo   <= w_lo_sq[35:0];
            r4_vl   <= w_vl_sq[35:0];
            r4_low  <= w_low;
            r4_vlow <= w_vlow;
            r4_tc   <= w_tc[18:0];
        end
        if (w_en[5]) begin
            r5_d1    <= r4_d1;
            r5_off   <= r4_off;
            r5_sens  <= r4_sens;
            r5_off2  <= n5_off2;
            r5_sens2 <= n5_sens2;
            r5_low   <= r4_low;
            r5_vlow  <= r4_vlow;
            r5_tc    <= r4_tc;
        end
        if (w_en[6]) begin
            r6_d1    <= r5_d1;
            r6_offc  <= n6_offc;
            r6_sensc <= n6_sensc;
            r6_tc    <= r5_tc;
        end
        if (w_en[7]) begin
            r7_ph  <= n7_ph;
            r7_pl  <= n7_pl;
            r7_off <= r6_offc;
            r7_tc  <= r6_tc;
        end
        if (w_en[8]) begin
            r8_x   <= n8_x;
            r8_off <= r7_off;
            r8_tc  <= r7_tc;
        end
        if (w_en[9]) begin
            r9_q  <= n9_q;
            r9_tc <= r8_tc;
        end
        if (w_en[10]) begin
            r10_p  <= n10_p;
            r10_tc <= r9_tc;
        end
    end

    assign o_pressure_pa       = r10_p;
    assign o_temperature_centi = r10_tc;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v[1])
        else $error("accepted beat did not enter the first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[9] && !w_en[9]) |=> r_v[9])
        else $error("stalled stage lost its beat");

    a_no_corr_warm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && !r5_low) |-> (r5_off2 == '0 && r5_sens2 == '0))
        else $error("second-order correction applied above reference temperature");

    a_vlow_implies_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && r5_vlow) |-> r5_low)
        else $error("very-low flag set without low flag");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_v[9]))
        else $error("output valid rose without a beat behind it");

endmodule
